/* hw/rtl/mmpq_pkg.sv */
package mmpq_pkg;

  localparam int DEPTH       = 256;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* hw/rtl/mmpq_if.sv */
interface mmpq_in_if;
  import mmpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface mmpq_out_if;
  import mmpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_OUT_W-1:0]   entry_count;

  modport source (output valid, output result_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input result_value, input status, input entry_count,
                output ready);
endinterface

interface mmpq_cfg_if;
  logic valid;
  logic ready;
  logic order_mode;

  modport source (output valid, output order_mode, input ready);
  modport sink (input valid, input order_mode, output ready);
endinterface

/* hw/rtl/mmpq_ram.sv */
module mmpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/mmpq_ctrl.sv */
module mmpq_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [mmpq_pkg::OP_W-1:0] in_operation,
  output logic                      in_ready,
  input  mmpq_pkg::dp_sts_t         sts,
  output mmpq_pkg::dp_cmd_t         cmd
);
  import mmpq_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        needs_scan;

  assign needs_scan = ((in_operation == OP_DEQUEUE) || (in_operation == OP_PEEK)) &&
                      !sts.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = needs_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/mmpq_dp.sv */
module mmpq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mmpq_pkg::OP_W-1:0]           in_operation,
  input  logic signed [mmpq_pkg::DATA_W-1:0]  in_value,
  input  mmpq_pkg::dp_cmd_t                   cmd,
  output mmpq_pkg::dp_sts_t                   sts,
  mmpq_out_if.source                          out_chan,
  mmpq_cfg_if.sink                            cfg_chan
);
  import mmpq_pkg::*;

  logic                      order_mode_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [OP_W-1:0]           op_r;
  logic signed [DATA_W-1:0]  val_r;
  logic [ADDR_W-1:0]         scan_idx_r;
  logic                      cmp_valid_r;
  logic [ADDR_W-1:0]         cmp_idx_r;
  logic signed [DATA_W-1:0]  best_r;
  logic [ADDR_W-1:0]         best_idx_r;
  logic signed [DATA_W-1:0]  last_r;
  logic [DATA_W-1:0]         rdata;
  logic signed [DATA_W-1:0]  rdata_s;
  logic                      take_new;
  logic                      full;
  logic                      empty;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [DATA_W-1:0]         wr_data;
  logic signed [DATA_W-1:0]  res;
  logic [STATUS_W-1:0]       status;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_value_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [COUNT_OUT_W-1:0]    out_count_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      order_mode_r <= cfg_chan.order_mode;
    end
  end

  mmpq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.scan_rd),
    .raddr (scan_idx_r),
    .rdata (rdata)
  );

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign sts.empty     = empty;
  assign sts.scan_last = ({1'b0, scan_idx_r} == CNT_W'(count_r - 1'b1));
  assign sts.out_free  = !out_valid_r || out_chan.ready;

  assign rdata_s  = rdata;
  assign take_new = (cmp_idx_r == '0) ||
                    (order_mode_r ? (rdata_s > best_r) : (rdata_s < best_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      val_r <= in_value;
    end
    if (cmd.load) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    cmp_idx_r <= scan_idx_r;
    if (cmp_valid_r) begin
      last_r <= rdata_s;
      if (take_new) begin
        best_r     <= rdata_s;
        best_idx_r <= cmp_idx_r;
      end
    end
  end

  // A dequeue fills the vacated slot with the rear entry; only values leave the queue.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = count_r[ADDR_W-1:0];
    wr_data   = val_r;
    count_nxt = count_r;
    res       = '0;
    status    = STS_OK;
    case (op_r)
      OP_ENQUEUE: begin
        if (full) begin
          status = STS_FULL;
        end else begin
          wr_en     = cmd.finish;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (empty) begin
          status = STS_EMPTY;
        end else begin
          wr_en     = cmd.finish;
          wr_addr   = best_idx_r;
          wr_data   = last_r;
          count_nxt = count_r - 1'b1;
          res       = best_r;
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status = STS_EMPTY;
        end else begin
          res = best_r;
        end
      end
      default: begin
        status = STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_valid_r <= cmd.scan_rd;
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r  <= res;
      out_status_r <= status;
      out_count_r  <= COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_value_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.entry_count  = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("Entry count exceeds capacity.");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_chan.ready))
    else $error("Result overwrote a transaction not yet taken.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> ({1'b0, scan_idx_r} < count_r))
    else $error("Scan read beyond the live entries.");

  a_dequeue_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (op_r == OP_DEQUEUE) && !empty) |=>
      (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("Dequeue did not remove exactly one entry.");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!cmd.scan_rd && !cmd.finish))
    else $error("Controller issued overlapping commands.");
`endif

endmodule

/* hw/rtl/min_max_priority_queue_top.sv */
// Bounded priority queue of up to 256 signed 32-bit values, served smallest first or, when the
// order_mode register is set, largest first. Each input transaction (enqueue, dequeue or peek)
// yields exactly one result transaction carrying the served value, a status (ok, full, empty)
// and the entry count after the operation. An enqueue, an unused operation code, or any
// operation rejected as full or empty goes from the idle state straight to the done state.
// A dequeue or peek on live entries passes through the scan and last states, as the entry
// memory is scanned one word per cycle through its single read port against one comparator. A
// new transaction is taken while the previous result still waits on the output channel.
// Entries are not kept in arrival order: a dequeue moves the rear entry to the slot it frees.
module min_max_priority_queue_top (
  input  logic       clk,
  input  logic       rst_n,
  mmpq_in_if.sink    in_chan,
  mmpq_out_if.source out_chan,
  mmpq_cfg_if.sink   cfg_chan
);
  import mmpq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mmpq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_chan.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mmpq_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_chan.operation),
    .in_value     (in_chan.value),
    .cmd          (cmd),
    .sts          (sts),
    .out_chan     (out_chan),
    .cfg_chan     (cfg_chan)
  );

endmodule

/* tb/min_max_priority_queue_top_tb.sv */
`timescale 1ns / 1ps

module min_max_priority_queue_top_tb;
  import mmpq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1950;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_GAP     = 13;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic [COUNT_OUT_W-1:0]   count;
  } result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_MODE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic                     pinned;
    result_t                  known;
  } dir_row_t;

  logic clk;
  logic rst_n;

  mmpq_in_if  in_chan ();
  mmpq_out_if out_chan ();
  mmpq_cfg_if cfg_chan ();

  min_max_priority_queue_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  logic signed [DATA_W-1:0] held[$];
  result_t                  awaited_results[$];
  bit                       serve_largest;
  bit                       back_to_back;
  bit                       hold_request;
  int                       failures;
  int                       items_sent;
  int                       results_checked;
  int                       op_tally[4];
  int                       full_hits;
  int                       empty_hits;
  int                       order_writes;
  int                       deepest;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Timed out with %0d results still outstanding.", awaited_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit serves_first(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
    return serve_largest ? (a > b) : (a < b);
  endfunction

  function automatic result_t serve_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v);
    result_t r;
    int      best;
    r = '0;
    r.status = STS_OK;
    best = 0;
    case (op)
      OP_ENQUEUE: begin
        if (held.size() >= DEPTH) begin
          r.status = STS_FULL;
          full_hits++;
        end else begin
          held.push_back(v);
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (held.size() == 0) begin
          r.status = STS_EMPTY;
          empty_hits++;
        end else begin
          for (int i = 1; i < held.size(); i++)
            if (serves_first(held[i], held[best])) best = i;
          r.value = held[best];
          if (op == OP_DEQUEUE) held.delete(best);
        end
      end
      default: ;
    endcase
    r.count = COUNT_OUT_W'(held.size());
    if (held.size() > deepest) deepest = held.size();
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return $signed($urandom_range(0, 16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) return OP_ENQUEUE;
    if (r < 15) return OP_DEQUEUE;
    if (r < 19) return OP_PEEK;
    return OP_UNUSED;
  endfunction

  function automatic dir_row_t row_plain(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.value = v;
    return r;
  endfunction

  function automatic dir_row_t row_known(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v,
                                         logic signed [DATA_W-1:0] rv, status_t st, int cnt);
    dir_row_t r;
    r = row_plain(op, v);
    r.pinned = 1'b1;
    r.known.value = rv;
    r.known.status = st;
    r.known.count = COUNT_OUT_W'(cnt);
    return r;
  endfunction

  function automatic dir_row_t row_mode(bit largest);
    dir_row_t r;
    r = '0;
    r.kind = ROW_MODE;
    r.value = largest;
    return r;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v,
                           bit pinned = 1'b0, result_t pinned_res = '0);
    int      gap;
    result_t predicted;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= op;
    in_chan.value <= v;
    do @(posedge clk); while (!in_chan.ready);
    predicted = serve_op(op, v);
    awaited_results.push_back(pinned ? pinned_res : predicted);
    items_sent++;
    op_tally[op]++;
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(bit largest);
    settle();
    cfg_chan.valid <= 1'b1;
    cfg_chan.order_mode <= largest;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    serve_largest = largest;
    order_writes++;
  endtask

  task automatic check_result();
    result_t want;
    results_checked++;
    if (awaited_results.size() == 0) begin
      $error("Result transaction arrived with nothing outstanding.");
      failures++;
    end else begin
      want = awaited_results.pop_front();
      if (out_chan.result_value !== want.value) begin
        $error("result_value: expected %0d, got %0d", want.value, out_chan.result_value);
        failures++;
      end
      if (out_chan.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_chan.status);
        failures++;
      end
      if (out_chan.entry_count !== want.count) begin
        $error("entry_count: expected %0d, got %0d", want.count, out_chan.entry_count);
        failures++;
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      check_result();
    end
  end

  initial begin : stimulus
    dir_row_t steps[$];
    int       phase;
    int       fill_runs;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.operation <= OP_ENQUEUE;
    in_chan.value <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.order_mode <= 1'b0;
    steps = '{
      row_mode(1'b0),
      row_known(OP_DEQUEUE, '0, '0, STS_EMPTY, 0),
      row_known(OP_PEEK, -32'sd1, '0, STS_EMPTY, 0),
      row_known(OP_UNUSED, -32'sd1, '0, STS_OK, 0),
      row_known(OP_ENQUEUE, 32'sh7FFF_FFFF, '0, STS_OK, 1),
      row_known(OP_ENQUEUE, 32'sh8000_0000, '0, STS_OK, 2),
      row_known(OP_ENQUEUE, '0, '0, STS_OK, 3),
      row_known(OP_ENQUEUE, -32'sd1, '0, STS_OK, 4),
      row_known(OP_ENQUEUE, 32'sd5, '0, STS_OK, 5),
      row_known(OP_ENQUEUE, 32'sd5, '0, STS_OK, 6),
      row_known(OP_PEEK, '0, 32'sh8000_0000, STS_OK, 6),
      row_known(OP_DEQUEUE, '0, 32'sh8000_0000, STS_OK, 5),
      row_plain(OP_DEQUEUE, 32'sh5A5A_A5A5),
      row_plain(OP_UNUSED, '0),
      row_mode(1'b1),
      row_known(OP_PEEK, '0, 32'sh7FFF_FFFF, STS_OK, 4),
      row_known(OP_DEQUEUE, '0, 32'sh7FFF_FFFF, STS_OK, 3),
      row_plain(OP_DEQUEUE, '0),
      row_plain(OP_DEQUEUE, '0),
      row_plain(OP_DEQUEUE, '0),
      row_known(OP_DEQUEUE, '0, '0, STS_EMPTY, 0),
      row_plain(OP_PEEK, '0),
      row_plain(OP_ENQUEUE, 32'sh8000_0000),
      row_plain(OP_PEEK, '0),
      row_plain(OP_DEQUEUE, '0)
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[k]) begin
      if (steps[k].kind == ROW_MODE) set_order(steps[k].value[0]);
      else send_item(steps[k].op, steps[k].value, steps[k].pinned, steps[k].known);
    end

    phase = 0;
    fill_runs = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      back_to_back = ($urandom_range(0, 5) == 0);
      if (phase % 3 == 0) set_order($urandom_range(0, 1));
      else if (phase % 4 == 0) settle();
      if (phase == 4) begin
        // The sink stalls while the source keeps pushing, so the input backs up.
        hold_request = 1'b1;
        repeat (16) send_item(pick_op(), pick_value());
      end else if (phase % 7 == 2 && fill_runs < 2) begin
        fill_runs++;
        repeat (DEPTH - held.size() + $urandom_range(1, 4)) send_item(OP_ENQUEUE, pick_value());
      end else if (held.size() > 160 || phase % 7 == 5) begin
        repeat (held.size() + $urandom_range(1, 3))
          send_item(($urandom_range(0, 3) == 0) ? OP_PEEK : OP_DEQUEUE, pick_value());
      end else begin
        repeat ($urandom_range(16, 64)) send_item(pick_op(), pick_value());
      end
    end

    back_to_back = 1'b0;
    settle();
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions: %0d enqueue, %0d dequeue, %0d peek, %0d unused code.",
             items_sent, op_tally[OP_ENQUEUE], op_tally[OP_DEQUEUE], op_tally[OP_PEEK],
             op_tally[OP_UNUSED]);
    $display("Checked %0d results; %0d full, %0d empty, %0d order writes, peak depth %0d.",
             results_checked, full_hits, empty_hits, order_writes, deepest);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mmpq_pkg.sv
hw/rtl/mmpq_if.sv
hw/rtl/mmpq_ram.sv
hw/rtl/mmpq_ctrl.sv
hw/rtl/mmpq_dp.sv
hw/rtl/min_max_priority_queue_top.sv
tb/min_max_priority_queue_top_tb.sv
